// ----- hw/rtl/pbrb_pkg.sv -----
`default_nettype none

package pbrb_pkg;

    // Default geometry of the frame store.
    localparam int ROWS_DEF      = 8;
    localparam int ROW_BYTES_DEF = 64;

    // Width register and the internal width that holds a clamped pixel count.
    localparam int             WIDTH_W     = 10;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 10'd512;
    localparam int             EW_W        = 12;

    // Request types.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // Request word.
    typedef struct packed {
        logic       req_type;
        logic [2:0] row_index;
        logic [8:0] bit_pos;
        logic [3:0] bit_count;
        logic [7:0] src_byte;
    } req_t;

    // Response word.
    typedef struct packed {
        logic [7:0] read_data;
        logic       out_of_range;
    } rsp_t;

    // What the merge unit hands back to the sequencer.
    typedef struct packed {
        rsp_t        rsp;
        logic [15:0] merged;
        logic        wr_first;
        logic        wr_second;
    } merge_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pbrb_ram.sv -----
`default_nettype none

module pbrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port; the read data holds
    // until the next read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pbrb_merge.sv -----
`default_nettype none

module pbrb_merge (
    input  wire pbrb_pkg::req_t               item,
    input  wire logic                         row_ok,
    input  wire logic [pbrb_pkg::EW_W-1:0]    eff_width,
    input  wire logic [7:0]                   win_first,
    input  wire logic [7:0]                   win_second,
    output pbrb_pkg::merge_t                  res
);

    logic [15:0] win;
    logic [15:0] shifted;
    logic [15:0] wmask16;
    logic [15:0] wdata16;
    logic [7:0]  rd_keep;
    logic [7:0]  wmask8;
    logic [3:0]  cnt;
    logic [2:0]  off;
    logic        rd_oor;
    logic        wr_oor;
    logic        in_w;
    logic        sel;
    logic [pbrb_pkg::EW_W-1:0] pix;

    always_comb
    begin
        // Saturate the count and locate the window within the two bytes.
        cnt     = (item.bit_count > 4'd8) ? 4'd8 : item.bit_count;
        off     = item.bit_pos[2:0];
        win     = {win_first, win_second};
        rd_keep = '0;
        wmask8  = '0;
        rd_oor  = 1'b0;
        wr_oor  = 1'b0;

        // Each of the eight pixels is checked against the frame width on its own.
        for (int k = 0; k < 8; k++)
        begin
            pix = pbrb_pkg::EW_W'(item.bit_pos) + pbrb_pkg::EW_W'(k);
            in_w = (pix < eff_width);
            sel  = (4'(k) < cnt);
            rd_keep[7-k] = in_w;
            wmask8[7-k]  = sel & in_w;
            rd_oor       = rd_oor | ~in_w;
            wr_oor       = wr_oor | (sel & ~in_w);
        end

        // Extract for reads, masked merge for writes.
        shifted = win << off;
        wmask16 = {wmask8, 8'h00} >> off;
        wdata16 = {item.src_byte, 8'h00} >> off;
        res.merged = (win & ~wmask16) | (wdata16 & wmask16);

        if (!row_ok)
        begin
            res.rsp.read_data    = 8'h00;
            res.rsp.out_of_range = (item.req_type == pbrb_pkg::REQ_READ) || (cnt != 4'd0);
            res.wr_first         = 1'b0;
            res.wr_second        = 1'b0;
        end
        else if (item.req_type == pbrb_pkg::REQ_READ)
        begin
            res.rsp.read_data    = shifted[15:8] & rd_keep;
            res.rsp.out_of_range = rd_oor;
            res.wr_first         = 1'b0;
            res.wr_second        = 1'b0;
        end
        else
        begin
            res.rsp.read_data    = 8'h00;
            res.rsp.out_of_range = wr_oor;
            res.wr_first         = |wmask16[15:8];
            res.wr_second        = |wmask16[7:0];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/packed_bit_row_blit_top.sv -----
// Bit-aligned frame store of ROWS rows of ROW_BYTES bytes, pixels MSB first.
// Request channel (req_valid, req_stall, req): a write word merges the top
// bit_count bits of src_byte into a row at bit_pos; a read word fetches the
// eight pixels that start at bit_pos. Pixels at or past the frame width read
// as zero and are never written; out_of_range then reports the clip.
// Response channel (rsp_valid, rsp_stall, rsp): exactly one word per request.
// Configuration channel (cfg_valid, cfg_ready, cfg_data) writes the frame width;
// cfg_ready is always high and writes belong to idle periods.
// Timing: the store is a single-port-write, registered-read RAM. A request reads
// its two bytes in consecutive cycles (IDLE, FETCH) and merges them in MERGE,
// which loads the response register and waits while that register is stalled.
// A read, or a write within one byte, then returns to IDLE; a write that
// changes the second byte first writes that byte back on its own in WRITE.
// Reset: the width returns to 512 and a clearing pass writes zero to every one
// of the ROWS*ROW_BYTES entries (512 by default), one per cycle; req_stall is
// high during the pass and in every state but IDLE.
// When the receiver stalls, the finished word waits in the output register; one
// more request is accepted and holds in its merge step until the register frees.
`default_nettype none

module packed_bit_row_blit_top #(
    parameter int ROWS      = pbrb_pkg::ROWS_DEF,
    parameter int ROW_BYTES = pbrb_pkg::ROW_BYTES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire pbrb_pkg::req_t                  req,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output pbrb_pkg::rsp_t                       rsp,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pbrb_pkg::WIDTH_W-1:0]    cfg_data
);

    localparam int DEPTH  = ROWS * ROW_BYTES;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FULL_W = ROW_BYTES * 8;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_FETCH = 5'b00100,
        ST_MERGE = 5'b01000,
        ST_WRITE = 5'b10000
    } state_t;

    state_t                         state_reg, state_next;
    logic [AW-1:0]                  clr_addr_reg;
    logic [pbrb_pkg::WIDTH_W-1:0]   width_reg;
    pbrb_pkg::req_t                 item_reg;
    logic                           row_ok_reg;
    logic [AW-1:0]                  addr0_reg;
    logic [AW-1:0]                  addr1_reg;
    logic [7:0]                     d0_reg;
    logic [7:0]                     wb_data_reg;
    logic                           rsp_valid_reg;
    pbrb_pkg::rsp_t                 rsp_reg;

    logic                           accept;
    logic                           proceed;
    logic                           row_ok_in;
    logic [AW-1:0]                  addr0_in;
    logic [AW-1:0]                  addr1_in;
    logic [pbrb_pkg::EW_W-1:0]      eff_width;
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [7:0]                     ram_wdata;
    logic                           ram_re;
    logic [AW-1:0]                  ram_raddr;
    logic [7:0]                     ram_rdata;
    pbrb_pkg::merge_t               mres;

    // Store address of a byte column in a row; columns past the row and rows
    // past the store fall back to a harmless in-range entry.
    function automatic logic [AW-1:0] addr_of(input logic [2:0] row, input logic ok,
                                              input logic [9:0] col);
        int r;
        int c;
        r = ok ? int'(row) : 0;
        c = (int'(col) < ROW_BYTES) ? int'(col) : 0;
        return AW'(r * ROW_BYTES + c);
    endfunction

    // Handshakes.
    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign proceed   = !rsp_valid_reg || !rsp_stall;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Request decode at acceptance.
    assign row_ok_in = (int'(req.row_index) < ROWS);
    assign addr0_in  = addr_of(req.row_index, row_ok_in, 10'(req.bit_pos[8:3]));
    assign addr1_in  = addr_of(req.row_index, row_ok_in, 10'(req.bit_pos[8:3]) + 10'd1);

    // Width clamped to the row length.
    assign eff_width = (pbrb_pkg::EW_W'(width_reg) < pbrb_pkg::EW_W'(FULL_W))
                     ? pbrb_pkg::EW_W'(width_reg) : pbrb_pkg::EW_W'(FULL_W);

    pbrb_merge u_merge (
        .item       (item_reg),
        .row_ok     (row_ok_reg),
        .eff_width  (eff_width),
        .win_first  (d0_reg),
        .win_second (ram_rdata),
        .res        (mres)
    );

    // Memory port selection per state.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr0_reg;
        ram_wdata = mres.merged[15:8];
        ram_re    = 1'b0;
        ram_raddr = addr0_in;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = 8'h00;
            end
            ST_IDLE:
            begin
                ram_re = accept;
            end
            ST_FETCH:
            begin
                ram_re    = 1'b1;
                ram_raddr = addr1_reg;
            end
            ST_MERGE:
            begin
                ram_we = proceed && mres.wr_first;
            end
            ST_WRITE:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr1_reg;
                ram_wdata = wb_data_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    pbrb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                if (proceed)
                begin
                    state_next = mres.wr_second ? ST_WRITE : ST_IDLE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            width_reg     <= pbrb_pkg::WIDTH_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cfg_valid && cfg_ready)
            begin
                width_reg <= cfg_data;
            end
            if (state_reg == ST_MERGE && proceed)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg   <= req;
            row_ok_reg <= row_ok_in;
            addr0_reg  <= addr0_in;
            addr1_reg  <= addr1_in;
        end
        if (state_reg == ST_FETCH)
        begin
            d0_reg <= ram_rdata;
        end
        if (state_reg == ST_MERGE && proceed)
        begin
            wb_data_reg <= mres.merged[7:0];
            rsp_reg     <= mres.rsp;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pbrb_checker.sv -----
`default_nettype none

module pbrb_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    input  wire logic                            req_stall,
    input  wire logic                            rsp_valid,
    input  wire logic                            rsp_stall,
    input  wire pbrb_pkg::rsp_t                  rsp,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready
);

    logic [1:0] pend_reg, pend_next;
    logic       req_acc;
    logic       rsp_acc;

    assign req_acc = req_valid && !req_stall;
    assign rsp_acc = rsp_valid && !rsp_stall;

    // Words accepted whose responses have not yet been taken.
    always_comb
    begin
        pend_next = pend_reg + 2'(req_acc) - 2'(rsp_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // A stalled response holds its word.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("response changed while stalled");

    // One request at a time: the block is busy right after an acceptance.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> req_stall)
        else $error("request accepted while previous one in flight");

    // At most one word in flight plus one waiting in the output register.
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg != 2'd3))
        else $error("too many outstanding requests");

    // A response is never produced without an outstanding request.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (pend_reg != 2'd0))
        else $error("response without request");

    // The width register is always writable.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind packed_bit_row_blit_top pbrb_checker u_pbrb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
